/* sv/omp_pkg.sv */
`default_nettype none
package omp_pkg;

  localparam int MAX_OBSTACLES = 16;
  localparam logic [5:0] MAX_STEPS = 6'd63;

  localparam int HALF_TURN    = 25736;
  localparam int FULL_TURN    = 51472;
  localparam int QUARTER_TURN = 12868;
  // wrap offset: a multiple of a full turn that keeps every yaw sum positive
  localparam int WRAP_BIAS    = FULL_TURN * 2048;
  localparam int WRAP_ROUNDS  = 12;

  localparam int CORDIC_ROUNDS = 17;
  localparam int CORDIC_GAIN   = 652032874;
  localparam int SQRT_ROUNDS   = 32;

  localparam logic [1:0] CFG_RATE    = 2'd0;
  localparam logic [1:0] CFG_STEP    = 2'd1;
  localparam logic [1:0] CFG_HORIZON = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_STORE, OP_MDX, OP_MDY, OP_MOM, OP_SQX, OP_SQY, OP_SQA,
    OP_SQRT, OP_HINIT, OP_WSTEP, OP_HSET, OP_MPX, OP_MPY, OP_MPW, OP_YADD,
    OP_CINIT, OP_CSTEP, OP_VC, OP_VS, OP_VEND
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [5:0] iter;
    logic       path_end;
  } cmd_t;

  typedef struct packed {
    logic seen;
    logic idx_ok;
    logic last;
    logic path;
    logic first_step;
  } stat_t;

  function automatic logic signed [20:0] atan_q16(input logic [4:0] i);
    logic signed [20:0] r;
    case (i)
      5'd0:    r = 21'sd51472;
      5'd1:    r = 21'sd30386;
      5'd2:    r = 21'sd16055;
      5'd3:    r = 21'sd8150;
      5'd4:    r = 21'sd4091;
      5'd5:    r = 21'sd2047;
      5'd6:    r = 21'sd1024;
      5'd7:    r = 21'sd512;
      5'd8:    r = 21'sd256;
      5'd9:    r = 21'sd128;
      5'd10:   r = 21'sd64;
      5'd11:   r = 21'sd32;
      5'd12:   r = 21'sd16;
      5'd13:   r = 21'sd8;
      5'd14:   r = 21'sd4;
      5'd15:   r = 21'sd2;
      5'd16:   r = 21'sd1;
      default: r = 21'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) r = 32'sh7fffffff;
    else if (v < -36'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

/* sv/omp_in_if.sv */
`default_nettype none
interface omp_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         obstacle_index;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [15:0] heading;
  modport source(output valid, obstacle_index, pos_x, pos_y, heading, input ready);
  modport sink(input valid, obstacle_index, pos_x, pos_y, heading, output ready);
endinterface
`default_nettype wire

/* sv/omp_out_if.sv */
`default_nettype none
interface omp_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         obstacle_id;
  logic [5:0]         step_index;
  logic signed [31:0] line_x;
  logic signed [31:0] line_y;
  logic signed [15:0] line_yaw;
  logic signed [31:0] turn_x;
  logic signed [31:0] turn_y;
  logic signed [15:0] turn_yaw;
  logic               final_step;
  modport source(output valid, obstacle_id, step_index, line_x, line_y, line_yaw,
                 turn_x, turn_y, turn_yaw, final_step, input ready);
  modport sink(input valid, obstacle_id, step_index, line_x, line_y, line_yaw,
               turn_x, turn_y, turn_yaw, final_step, output ready);
endinterface
`default_nettype wire

/* sv/obstacle_motion_predictor_core.sv */
// Obstacle motion predictor, constant speed and constant turn rate.
// in_ch : one pose word per sample (obstacle_index, pos_x, pos_y, heading),
//         taken when valid and ready are high at a rising edge of clk.
// out_ch: one word per prediction step, step 0 being the observed pose;
//         final_step marks the last word of a run.
// cfg_*: write port, index 0 sample_rate_hz, 1 step_time, 2 horizon_steps;
//         the user writes them only while the block is idle; the block does not enforce it.
// The first sample of an obstacle is only stored and produces no words.
// Sequence: a first sample of an obstacle is stored and the block is then
//   ready again. A later sample runs setup, with the 32-round square root,
//   then per step the 12-round yaw wrap and 17-round CORDIC of the turning
//   path; all products share one 34x34 multiplier. The straight path
//   reuses its heading after step 0.
// One item is in work at a time; in_ch.ready is high only between runs.
// A stalled receiver holds the current word and freezes the run.
// Reset (rst, synchronous) clears the per-obstacle seen flags and restores
// the register defaults 10 Hz, 6554 (0.1 s), 35 steps.
`default_nettype none
module obstacle_motion_predictor_core (
  input  wire logic  clk,
  input  wire logic  rst,
  omp_in_if.sink     in_ch,
  omp_out_if.source  out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  omp_pkg::cmd_t  cmd;
  omp_pkg::stat_t stat;

  omp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  omp_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .obstacle_index (in_ch.obstacle_index),
    .pos_x          (in_ch.pos_x),
    .pos_y          (in_ch.pos_y),
    .heading        (in_ch.heading),
    .obstacle_id    (out_ch.obstacle_id),
    .step_index     (out_ch.step_index),
    .line_x         (out_ch.line_x),
    .line_y         (out_ch.line_y),
    .line_yaw       (out_ch.line_yaw),
    .turn_x         (out_ch.turn_x),
    .turn_y         (out_ch.turn_y),
    .turn_yaw       (out_ch.turn_yaw),
    .final_step     (out_ch.final_step)
  );

endmodule
`default_nettype wire

/* sv/omp_ctrl.sv */
`default_nettype none
module omp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire omp_pkg::stat_t stat,
  output omp_pkg::cmd_t      cmd
);

  typedef enum logic [21:0] {
    S_IDLE  = 22'h000001, S_CHECK = 22'h000002, S_MDY   = 22'h000004,
    S_MOM   = 22'h000008, S_SQX   = 22'h000010, S_SQY   = 22'h000020,
    S_SQA   = 22'h000040, S_SQRT  = 22'h000080, S_HINIT = 22'h000100,
    S_HWRAP = 22'h000200, S_HSET  = 22'h000400, S_EMIT  = 22'h000800,
    S_MPX   = 22'h001000, S_MPY   = 22'h002000, S_MPW   = 22'h004000,
    S_YADD  = 22'h008000, S_WRAP  = 22'h010000, S_CINIT = 22'h020000,
    S_CSTEP = 22'h040000, S_VC    = 22'h080000, S_VS    = 22'h100000,
    S_VEND  = 22'h200000
  } state_t;

  state_t     state, state_next;
  logic [5:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    cmd.op       = omp_pkg::OP_NONE;
    cmd.iter     = cnt;
    cmd.path_end = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = omp_pkg::OP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!stat.idx_ok) begin
          state_next = S_IDLE;
        end else if (!stat.seen) begin
          cmd.op     = omp_pkg::OP_STORE;
          state_next = S_IDLE;
        end else begin
          cmd.op     = omp_pkg::OP_MDX;
          state_next = S_MDY;
        end
      end
      S_MDY: begin cmd.op = omp_pkg::OP_MDY; state_next = S_MOM; end
      S_MOM: begin cmd.op = omp_pkg::OP_MOM; state_next = S_SQX; end
      S_SQX: begin cmd.op = omp_pkg::OP_SQX; state_next = S_SQY; end
      S_SQY: begin cmd.op = omp_pkg::OP_SQY; state_next = S_SQA; end
      S_SQA: begin
        cmd.op     = omp_pkg::OP_SQA;
        cnt_next   = '0;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.op = omp_pkg::OP_SQRT;
        if (cnt == 6'(omp_pkg::SQRT_ROUNDS - 1)) begin
          cnt_next   = '0;
          state_next = S_HINIT;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      S_HINIT: begin
        cmd.op     = omp_pkg::OP_HINIT;
        cnt_next   = '0;
        state_next = S_HWRAP;
      end
      S_HWRAP: begin
        cmd.op = omp_pkg::OP_WSTEP;
        if (cnt == 6'(omp_pkg::WRAP_ROUNDS - 1)) begin
          cnt_next   = '0;
          state_next = S_HSET;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      S_HSET: begin cmd.op = omp_pkg::OP_HSET; state_next = S_EMIT; end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = stat.last ? S_IDLE : S_MPX;
      end
      S_MPX: begin cmd.op = omp_pkg::OP_MPX; state_next = S_MPY; end
      S_MPY: begin cmd.op = omp_pkg::OP_MPY; state_next = S_MPW; end
      S_MPW: begin
        cmd.op = omp_pkg::OP_MPW;
        // straight path keeps its heading: velocity only changes after step 0
        if (!stat.path && !stat.first_step) begin
          cmd.path_end = 1'b1;
          state_next   = S_MPX;
        end else begin
          state_next = S_YADD;
        end
      end
      S_YADD: begin
        cmd.op     = omp_pkg::OP_YADD;
        cnt_next   = '0;
        state_next = S_WRAP;
      end
      S_WRAP: begin
        cmd.op = omp_pkg::OP_WSTEP;
        if (cnt == 6'(omp_pkg::WRAP_ROUNDS - 1)) begin
          cnt_next   = '0;
          state_next = S_CINIT;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      S_CINIT: begin
        cmd.op     = omp_pkg::OP_CINIT;
        cnt_next   = '0;
        state_next = S_CSTEP;
      end
      S_CSTEP: begin
        cmd.op = omp_pkg::OP_CSTEP;
        if (cnt == 6'(omp_pkg::CORDIC_ROUNDS - 1)) begin
          cnt_next   = '0;
          state_next = S_VC;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      S_VC: begin cmd.op = omp_pkg::OP_VC; state_next = S_VS; end
      S_VS: begin cmd.op = omp_pkg::OP_VS; state_next = S_VEND; end
      S_VEND: begin
        cmd.op       = omp_pkg::OP_VEND;
        cmd.path_end = 1'b1;
        state_next   = stat.path ? S_EMIT : S_MPX;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* sv/omp_datapath.sv */
`default_nettype none
module omp_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire omp_pkg::cmd_t      cmd,
  output omp_pkg::stat_t          stat,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic [3:0]         obstacle_index,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [15:0] heading,
  output logic [3:0]              obstacle_id,
  output logic [5:0]              step_index,
  output logic signed [31:0]      line_x,
  output logic signed [31:0]      line_y,
  output logic signed [15:0]      line_yaw,
  output logic signed [31:0]      turn_x,
  output logic signed [31:0]      turn_y,
  output logic signed [15:0]      turn_yaw,
  output logic                    final_step
);

  logic [9:0]  rate;
  logic [15:0] st;
  logic [5:0]  horizon;

  logic signed [31:0] prev_x [omp_pkg::MAX_OBSTACLES];
  logic signed [31:0] prev_y [omp_pkg::MAX_OBSTACLES];
  logic signed [15:0] prev_h [omp_pkg::MAX_OBSTACLES];
  logic [omp_pkg::MAX_OBSTACLES-1:0] seen;

  logic [3:0]         idx;
  logic signed [31:0] x_r, y_r, mvx, mvy;
  logic signed [15:0] h_r;
  logic signed [31:0] old_x, old_y;
  logic signed [15:0] old_h;
  logic signed [26:0] om;
  logic signed [33:0] v;
  logic signed [31:0] px [2];
  logic signed [31:0] py [2];
  logic signed [15:0] yw [2];
  logic signed [33:0] vx [2];
  logic signed [33:0] vy [2];
  logic               path;
  logic [5:0]         k;
  logic signed [67:0] prod;
  logic [63:0]        sq_n, sq_r;
  logic [27:0]        wr;
  logic signed [33:0] cx, cy;
  logic signed [20:0] cz;
  logic               neg;

  logic               mul_en;
  logic signed [33:0] mul_a, mul_b;
  logic signed [32:0] dx, dy;
  logic signed [16:0] dh;
  logic signed [67:0] p16, p30;
  logic signed [35:0] r16, ysum, hsum, xsum, psum;
  logic signed [33:0] r30, cosv, sinv, xs, ys;
  logic [5:0]         sq_sh, nsteps;
  logic [63:0]        sq_bit, sq_rb;
  logic [27:0]        wc;
  logic signed [28:0] yv;
  logic signed [15:0] ywn;
  logic signed [16:0] ca;
  logic               cneg;

  assign dx   = 33'(x_r) - 33'(old_x);
  assign dy   = 33'(y_r) - 33'(old_y);
  assign dh   = 17'(h_r) - 17'(old_h);
  assign p16  = prod + 68'sd32768;
  assign r16  = p16[51:16];
  assign p30  = prod + 68'sd536870912;
  assign r30  = p30[63:30];
  assign xsum = 36'(px[path]) + r16;
  assign psum = 36'(py[path]) + r16;
  assign ysum = 36'(yw[path]) + r16 + 36'(omp_pkg::HALF_TURN) + 36'(omp_pkg::WRAP_BIAS);
  assign hsum = 36'(h_r) + 36'(omp_pkg::HALF_TURN) + 36'(omp_pkg::WRAP_BIAS);
  assign cosv = neg ? -cx : cx;
  assign sinv = neg ? -cy : cy;
  assign xs   = cx >>> cmd.iter[4:0];
  assign ys   = cy >>> cmd.iter[4:0];

  // restoring square root, two bits of the radicand per round
  assign sq_sh  = 6'd62 - {cmd.iter[4:0], 1'b0};
  assign sq_bit = 64'd1 << sq_sh;
  assign sq_rb  = sq_r + sq_bit;

  // wrap by reducing against full turn times 2^11 .. 2^0
  assign wc  = 28'(omp_pkg::WRAP_BIAS) >> cmd.iter[3:0];
  assign yv  = $signed({1'b0, wr}) - 29'sd25736;
  assign ywn = yv[15:0];

  always_comb begin
    cneg = 1'b0;
    ca   = 17'(ywn);
    if (ywn > 16'sd12868) begin
      ca   = 17'(ywn) - 17'sd25736;
      cneg = 1'b1;
    end else if (ywn < -16'sd12868) begin
      ca   = 17'(ywn) + 17'sd25736;
      cneg = 1'b1;
    end
  end

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = 34'(st);
    case (cmd.op)
      omp_pkg::OP_MDX: begin mul_a = 34'(dx); mul_b = 34'(rate); end
      omp_pkg::OP_MDY: begin mul_a = 34'(dy); mul_b = 34'(rate); end
      omp_pkg::OP_MOM: begin mul_a = 34'(dh); mul_b = 34'(rate); end
      omp_pkg::OP_SQX: begin mul_a = 34'(mvx); mul_b = 34'(mvx); end
      omp_pkg::OP_SQY: begin mul_a = 34'(mvy); mul_b = 34'(mvy); end
      omp_pkg::OP_MPX: mul_a = vx[path];
      omp_pkg::OP_MPY: mul_a = vy[path];
      omp_pkg::OP_MPW: mul_a = path ? 34'(om) : 34'sd0;
      omp_pkg::OP_VC:  begin mul_a = v; mul_b = cosv; end
      omp_pkg::OP_VS:  begin mul_a = v; mul_b = sinv; end
      default:         mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate    <= 10'd10;
      st      <= 16'd6554;
      horizon <= 6'd35;
      seen    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          omp_pkg::CFG_RATE:    rate    <= cfg_data[9:0];
          omp_pkg::CFG_STEP:    st      <= cfg_data;
          omp_pkg::CFG_HORIZON: horizon <= cfg_data[5:0];
          default: ;
        endcase
      end
      if (cmd.op == omp_pkg::OP_STORE) seen[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) prod <= mul_a * mul_b;
    if (cmd.path_end) begin
      path <= ~path;
      if (path) k <= k + 6'd1;
    end
    case (cmd.op)
      omp_pkg::OP_LOAD: begin
        idx   <= obstacle_index;
        x_r   <= pos_x;
        y_r   <= pos_y;
        h_r   <= heading;
        old_x <= prev_x[obstacle_index];
        old_y <= prev_y[obstacle_index];
        old_h <= prev_h[obstacle_index];
      end
      omp_pkg::OP_STORE: begin
        prev_x[idx] <= x_r;
        prev_y[idx] <= y_r;
        prev_h[idx] <= h_r;
      end
      omp_pkg::OP_MDY: mvx <= omp_pkg::sat32(prod[35:0] == prod[35:0] &&
                                             (prod > 68'sd2147483647 ||
                                              prod < -68'sd2147483648) ?
                                             (prod[67] ? -36'sd2147483649 :
                                                          36'sd2147483648) :
                                             prod[35:0]);
      omp_pkg::OP_MOM: mvy <= omp_pkg::sat32((prod > 68'sd2147483647 ||
                                              prod < -68'sd2147483648) ?
                                             (prod[67] ? -36'sd2147483649 :
                                                          36'sd2147483648) :
                                             prod[35:0]);
      omp_pkg::OP_SQX: begin
        om          <= prod[26:0];
        px[0]       <= x_r;  px[1] <= x_r;
        py[0]       <= y_r;  py[1] <= y_r;
        vx[0]       <= 34'(mvx); vx[1] <= 34'(mvx);
        vy[0]       <= 34'(mvy); vy[1] <= 34'(mvy);
        prev_x[idx] <= x_r;
        prev_y[idx] <= y_r;
        prev_h[idx] <= h_r;
        k           <= '0;
        path        <= 1'b0;
      end
      omp_pkg::OP_SQY: sq_n <= prod[63:0];
      omp_pkg::OP_SQA: begin
        sq_n <= sq_n + prod[63:0];
        sq_r <= '0;
      end
      omp_pkg::OP_SQRT: begin
        if (sq_n >= sq_rb) begin
          sq_n <= sq_n - sq_rb;
          sq_r <= (sq_r >> 1) + sq_bit;
        end else begin
          sq_r <= sq_r >> 1;
        end
      end
      omp_pkg::OP_HINIT: begin
        v  <= $signed({2'b00, sq_r[31:0]});
        wr <= hsum[27:0];
      end
      omp_pkg::OP_WSTEP: if (wr >= wc) wr <= wr - wc;
      omp_pkg::OP_HSET: begin
        yw[0] <= ywn;
        yw[1] <= ywn;
      end
      omp_pkg::OP_MPY: px[path] <= omp_pkg::sat32(xsum);
      omp_pkg::OP_MPW: py[path] <= omp_pkg::sat32(psum);
      omp_pkg::OP_YADD: wr <= ysum[27:0];
      omp_pkg::OP_CINIT: begin
        yw[path] <= ywn;
        neg      <= cneg;
        cx       <= 34'(omp_pkg::CORDIC_GAIN);
        cy       <= '0;
        cz       <= 21'(ca) <<< 3;
      end
      omp_pkg::OP_CSTEP: begin
        if (!cz[20]) begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - omp_pkg::atan_q16(cmd.iter[4:0]);
        end else begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + omp_pkg::atan_q16(cmd.iter[4:0]);
        end
      end
      omp_pkg::OP_VS:   vx[path] <= r30;
      omp_pkg::OP_VEND: vy[path] <= r30;
      default: ;
    endcase
  end

  assign nsteps = (horizon > omp_pkg::MAX_STEPS) ? omp_pkg::MAX_STEPS : horizon;

  assign stat.seen       = seen[idx];
  assign stat.idx_ok     = {28'd0, idx} < 32'(omp_pkg::MAX_OBSTACLES);
  assign stat.last       = (k == nsteps);
  assign stat.path       = path;
  assign stat.first_step = (k == 6'd0);

  assign obstacle_id = idx;
  assign step_index  = k;
  assign line_x      = px[0];
  assign line_y      = py[0];
  assign line_yaw    = yw[0];
  assign turn_x      = px[1];
  assign turn_y      = py[1];
  assign turn_yaw    = yw[1];
  assign final_step  = stat.last;

endmodule
`default_nettype wire

/* sv/omp_checker.sv */
`default_nettype none
module omp_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [5:0] step_index,
  input wire logic       final_step
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(step_index))
    else $error("output word changed under stall");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready during a run");

  // mid-run word taken: next step is still being computed
  a_mid_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !final_step |=> !in_ready && !out_valid)
    else $error("run ended early");

endmodule

bind obstacle_motion_predictor_core omp_checker u_omp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .step_index (out_ch.step_index),
  .final_step (out_ch.final_step)
);
`default_nettype wire
